// ===== rtl/v2alu_pkg.sv =====
// types, constants and helper functions for the 2d vector alu
`default_nettype none
package v2alu_pkg;

	localparam int DW = 32;
	localparam int PW = 64;
	localparam int RW = 33;
	localparam int SQ_CELLS = 32;
	localparam int DIV_CELLS = 64;
	localparam int LATENCY = 3 + SQ_CELLS + 1 + DIV_CELLS + 1;

	localparam logic [2:0] MODE_SUM   = 3'd0;
	localparam logic [2:0] MODE_DIFF  = 3'd1;
	localparam logic [2:0] MODE_DOT   = 3'd2;
	localparam logic [2:0] MODE_PERP  = 3'd3;
	localparam logic [2:0] MODE_LEN   = 3'd4;
	localparam logic [2:0] MODE_UNIT  = 3'd5;
	localparam logic [2:0] MODE_SETL  = 3'd6;
	localparam logic [2:0] MODE_SCALE = 3'd7;

	localparam logic [DW-1:0] ONE_Q   = 32'h0001_0000;
	localparam logic [DW-1:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [DW-1:0] NEG_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [2:0]    mode;
		logic [DW-1:0] rx;
		logic [DW-1:0] ry;
		logic [DW-1:0] rs;
		logic          ovf;
		logic          dz;
		logic          negx;
		logic          negy;
	} ctx_t;

	typedef struct packed {
		ctx_t          ctx;
		logic [PW-1:0] nx;
		logic [PW-1:0] ny;
	} sq_tag_t;

	typedef struct packed {
		logic [PW-1:0] v;
		logic [PW-1:0] r;
	} sq_st_t;

	typedef struct packed {
		logic [PW-1:0] nqx;
		logic [PW-1:0] nqy;
		logic [RW-1:0] remx;
		logic [RW-1:0] remy;
		logic [RW-1:0] d;
	} dv_st_t;

	function automatic logic [DW-1:0] mag32(input logic [DW-1:0] x);
		return x[DW-1] ? (~x + 32'd1) : x;
	endfunction

	// saturate sign and magnitude into q16.16, top bit is the overflow flag
	function automatic logic [DW:0] sat_sm(input logic neg, input logic [PW:0] m);
		logic [DW-1:0] v;
		logic          o;
		o = 1'b0;
		if (!neg) begin
			if (m > {33'd0, POS_MAX}) begin
				o = 1'b1;
				v = POS_MAX;
			end else begin
				v = m[DW-1:0];
			end
		end else begin
			if (m > {33'd0, NEG_MIN}) begin
				o = 1'b1;
				v = NEG_MIN;
			end else begin
				v = ~m[DW-1:0] + 32'd1;
			end
		end
		return {o, v};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/v2alu_sqrt_cell.sv =====
// one bit step of the pipelined square root chain
`default_nettype none
module v2alu_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_vld,
	input  v2alu_pkg::sq_st_t    in_st,
	input  v2alu_pkg::sq_tag_t   in_tag,
	output logic                 out_vld,
	output v2alu_pkg::sq_st_t    out_st,
	output v2alu_pkg::sq_tag_t   out_tag
);
	import v2alu_pkg::*;

	localparam logic [PW-1:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic          vld_q;
	sq_st_t        st_q;
	sq_tag_t       tag_q;
	sq_st_t        nxt;
	logic [PW-1:0] trial;

	always_comb begin
		trial = in_st.r + BIT;
		if (in_st.v >= trial) begin
			nxt.v = in_st.v - trial;
			nxt.r = (in_st.r >> 1) + BIT;
		end else begin
			nxt.v = in_st.v;
			nxt.r = in_st.r >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		st_q  <= nxt;
		tag_q <= in_tag;
	end

	assign out_vld = vld_q;
	assign out_st  = st_q;
	assign out_tag = tag_q;
endmodule
`default_nettype wire

// ===== rtl/v2alu_div_cell.sv =====
// one quotient bit step of the pipelined two lane divider chain
`default_nettype none
module v2alu_div_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_vld,
	input  v2alu_pkg::dv_st_t  in_st,
	input  v2alu_pkg::ctx_t    in_ctx,
	output logic               out_vld,
	output v2alu_pkg::dv_st_t  out_st,
	output v2alu_pkg::ctx_t    out_ctx
);
	import v2alu_pkg::*;

	logic        vld_q;
	dv_st_t      st_q;
	ctx_t        ctx_q;
	dv_st_t      nxt;
	logic [RW:0] shx;
	logic [RW:0] shy;
	logic        qbx;
	logic        qby;

	always_comb begin
		shx = {in_st.remx, in_st.nqx[PW-1]};
		shy = {in_st.remy, in_st.nqy[PW-1]};
		qbx = shx >= {1'b0, in_st.d};
		qby = shy >= {1'b0, in_st.d};
		nxt.d    = in_st.d;
		nxt.remx = qbx ? RW'(shx - {1'b0, in_st.d}) : shx[RW-1:0];
		nxt.remy = qby ? RW'(shy - {1'b0, in_st.d}) : shy[RW-1:0];
		nxt.nqx  = {in_st.nqx[PW-2:0], qbx};
		nxt.nqy  = {in_st.nqy[PW-2:0], qby};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		st_q  <= nxt;
		ctx_q <= in_ctx;
	end

	assign out_vld = vld_q;
	assign out_st  = st_q;
	assign out_ctx = ctx_q;
endmodule
`default_nettype wire

// ===== rtl/vector2d_alu.sv =====
// top level of the 2d vector alu in signed q16.16
// stages: input, products, sqrt start, sqrt cells, div start, div cells, output
// throughput: one item per cycle, busy stays low; the 32 square root cells and
// the 64 divider cells each hold one item, so all modes share the full latency
// reset: arst_n clears all valid bits at once, no result follows until a new item
// the receiver cannot stall, each result is shown for one cycle only
`default_nettype none
module vector2d_alu (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [2:0]  mode,
	input  wire  [31:0] a_x,
	input  wire  [31:0] a_y,
	input  wire  [31:0] b_x,
	input  wire  [31:0] b_y,
	input  wire  [31:0] scalar_in,
	output logic        done,
	output logic [31:0] res_x,
	output logic [31:0] res_y,
	output logic [31:0] res_scalar,
	output logic        div_zero,
	output logic        overflow
);
	import v2alu_pkg::*;

	// input register
	logic          vld_s1;
	logic [2:0]    mode_s1;
	logic [DW-1:0] ax_s1, ay_s1, bx_s1, by_s1, sc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mode_s1 <= mode;
			ax_s1   <= a_x;
			ay_s1   <= a_y;
			bx_s1   <= b_x;
			by_s1   <= b_y;
			sc_s1   <= scalar_in;
		end
	end

	// products
	logic [DW-1:0] axm, aym, bxm, bym, scm, op1, op2, fac;
	logic [DW:0]   ex_c, ey_c;

	always_comb begin
		axm = mag32(ax_s1);
		aym = mag32(ay_s1);
		bxm = mag32(bx_s1);
		bym = mag32(by_s1);
		scm = mag32(sc_s1);
		fac = (mode_s1 == MODE_UNIT) ? ONE_Q : scm;
		case (mode_s1)
			MODE_DOT: begin
				op1 = bxm;
				op2 = bym;
			end
			MODE_SCALE: begin
				op1 = scm;
				op2 = scm;
			end
			default: begin
				op1 = axm;
				op2 = aym;
			end
		endcase
		case (mode_s1)
			MODE_SUM: begin
				ex_c = {ax_s1[DW-1], ax_s1} + {bx_s1[DW-1], bx_s1};
				ey_c = {ay_s1[DW-1], ay_s1} + {by_s1[DW-1], by_s1};
			end
			MODE_DIFF: begin
				ex_c = {ax_s1[DW-1], ax_s1} - {bx_s1[DW-1], bx_s1};
				ey_c = {ay_s1[DW-1], ay_s1} - {by_s1[DW-1], by_s1};
			end
			MODE_PERP: begin
				ex_c = 33'd0 - {ay_s1[DW-1], ay_s1};
				ey_c = {ax_s1[DW-1], ax_s1};
			end
			default: begin
				ex_c = '0;
				ey_c = '0;
			end
		endcase
	end

	logic          vld_s2;
	logic [2:0]    mode_s2;
	logic [PW-1:0] m1_s2, m2_s2, nx_s2, ny_s2;
	logic [DW:0]   ex_s2, ey_s2;
	logic          sax_s2, say_s2, sbx_s2, sby_s2, ssc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		mode_s2 <= mode_s1;
		m1_s2   <= PW'(axm) * PW'(op1);
		m2_s2   <= PW'(aym) * PW'(op2);
		nx_s2   <= PW'(axm) * PW'(fac);
		ny_s2   <= PW'(aym) * PW'(fac);
		ex_s2   <= ex_c;
		ey_s2   <= ey_c;
		sax_s2  <= ax_s1[DW-1];
		say_s2  <= ay_s1[DW-1];
		sbx_s2  <= bx_s1[DW-1];
		sby_s2  <= by_s1[DW-1];
		ssc_s2  <= sc_s1[DW-1];
	end

	// direct results and square root start
	ctx_t        ctx_c;
	logic        n1, n2, dneg, fneg;
	logic [PW:0] dm, dr, smx, smy;
	logic [DW:0] exm, eym, satx, saty, sats;

	always_comb begin
		n1 = sax_s2 ^ sbx_s2;
		n2 = say_s2 ^ sby_s2;
		if (n1 == n2) begin
			dneg = n1;
			dm   = {1'b0, m1_s2} + {1'b0, m2_s2};
		end else if (m1_s2 >= m2_s2) begin
			dneg = n1;
			dm   = {1'b0, m1_s2 - m2_s2};
		end else begin
			dneg = n2;
			dm   = {1'b0, m2_s2 - m1_s2};
		end
		dr  = (dm >> 16) + {64'd0, dm[15]};
		smx = {17'd0, m1_s2[PW-1:16]} + {64'd0, m1_s2[15]};
		smy = {17'd0, m2_s2[PW-1:16]} + {64'd0, m2_s2[15]};
		exm = ex_s2[DW] ? (~ex_s2 + 33'd1) : ex_s2;
		eym = ey_s2[DW] ? (~ey_s2 + 33'd1) : ey_s2;
		fneg = (mode_s2 == MODE_SETL) && ssc_s2;

		ctx_c      = '0;
		ctx_c.mode = mode_s2;
		ctx_c.negx = sax_s2 ^ fneg;
		ctx_c.negy = say_s2 ^ fneg;
		satx = '0;
		saty = '0;
		sats = '0;
		case (mode_s2)
			MODE_SUM, MODE_DIFF, MODE_PERP: begin
				satx = sat_sm(ex_s2[DW], {32'd0, exm});
				saty = sat_sm(ey_s2[DW], {32'd0, eym});
			end
			MODE_DOT: begin
				sats = sat_sm(dneg, dr);
			end
			MODE_SCALE: begin
				satx = sat_sm(sax_s2 ^ ssc_s2, smx);
				saty = sat_sm(say_s2 ^ ssc_s2, smy);
			end
			default: begin
				satx = '0;
			end
		endcase
		ctx_c.rx  = satx[DW-1:0];
		ctx_c.ry  = saty[DW-1:0];
		ctx_c.rs  = sats[DW-1:0];
		ctx_c.ovf = satx[DW] | saty[DW] | sats[DW];
	end

	logic    vld_s3;
	sq_st_t  sqst_s3;
	sq_tag_t tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sqst_s3.v  <= m1_s2 + m2_s2;
		sqst_s3.r  <= '0;
		tag_s3.ctx <= ctx_c;
		tag_s3.nx  <= nx_s2;
		tag_s3.ny  <= ny_s2;
	end

	// square root chain
	logic    sq_vld [SQ_CELLS+1];
	sq_st_t  sq_st  [SQ_CELLS+1];
	sq_tag_t sq_tag [SQ_CELLS+1];

	assign sq_vld[0] = vld_s3;
	assign sq_st[0]  = sqst_s3;
	assign sq_tag[0] = tag_s3;

	for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sq
		v2alu_sqrt_cell #(.STEP(k)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (sq_vld[k]),
			.in_st   (sq_st[k]),
			.in_tag  (sq_tag[k]),
			.out_vld (sq_vld[k+1]),
			.out_st  (sq_st[k+1]),
			.out_tag (sq_tag[k+1])
		);
	end

	// rounded length and divider start
	sq_st_t        sq_end;
	sq_tag_t       tg_end;
	logic [PW-1:0] len;
	logic [DW:0]   satl;
	ctx_t          ctx_r;
	dv_st_t        dv_init;

	always_comb begin
		sq_end = sq_st[SQ_CELLS];
		tg_end = sq_tag[SQ_CELLS];
		len    = sq_end.r + {63'd0, sq_end.v > sq_end.r};
		satl   = sat_sm(1'b0, {1'b0, len});
		ctx_r  = tg_end.ctx;
		if (ctx_r.mode == MODE_LEN) begin
			ctx_r.rs  = satl[DW-1:0];
			ctx_r.ovf = satl[DW];
		end
		ctx_r.dz = ((ctx_r.mode == MODE_UNIT) || (ctx_r.mode == MODE_SETL)) && (len == '0);
		dv_init.nqx  = tg_end.nx;
		dv_init.nqy  = tg_end.ny;
		dv_init.remx = '0;
		dv_init.remy = '0;
		dv_init.d    = (len == '0) ? RW'(1) : len[RW-1:0];
	end

	logic   vld_r;
	dv_st_t dvst_r;
	ctx_t   ctx_rq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_r <= 1'b0;
		end else begin
			vld_r <= sq_vld[SQ_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		dvst_r <= dv_init;
		ctx_rq <= ctx_r;
	end

	// divider chain
	logic   dv_vld [DIV_CELLS+1];
	dv_st_t dv_st  [DIV_CELLS+1];
	ctx_t   dv_ctx [DIV_CELLS+1];

	assign dv_vld[0] = vld_r;
	assign dv_st[0]  = dvst_r;
	assign dv_ctx[0] = ctx_rq;

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_dv
		v2alu_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (dv_vld[j]),
			.in_st   (dv_st[j]),
			.in_ctx  (dv_ctx[j]),
			.out_vld (dv_vld[j+1]),
			.out_st  (dv_st[j+1]),
			.out_ctx (dv_ctx[j+1])
		);
	end

	// quotient rounding and result select
	dv_st_t      dv_end;
	ctx_t        cx;
	logic [PW:0] qx, qy;
	logic [DW:0] sqx, sqy;
	logic [DW-1:0] fx, fy, fs;
	logic        fo;

	always_comb begin
		dv_end = dv_st[DIV_CELLS];
		cx     = dv_ctx[DIV_CELLS];
		qx = {1'b0, dv_end.nqx} + {64'd0, dv_end.remx >= (dv_end.d - dv_end.remx)};
		qy = {1'b0, dv_end.nqy} + {64'd0, dv_end.remy >= (dv_end.d - dv_end.remy)};
		sqx = sat_sm(cx.negx, qx);
		sqy = sat_sm(cx.negy, qy);
		fx = cx.rx;
		fy = cx.ry;
		fs = cx.rs;
		fo = cx.ovf;
		if ((cx.mode == MODE_UNIT) || (cx.mode == MODE_SETL)) begin
			fs = '0;
			if (cx.dz) begin
				fx = '0;
				fy = '0;
				fo = 1'b0;
			end else begin
				fx = sqx[DW-1:0];
				fy = sqy[DW-1:0];
				fo = sqx[DW] | sqy[DW];
			end
		end
	end

	logic          done_q;
	logic [DW-1:0] rx_q, ry_q, rs_q;
	logic          dz_q, ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_vld[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		rx_q  <= fx;
		ry_q  <= fy;
		rs_q  <= fs;
		dz_q  <= cx.dz;
		ovf_q <= fo;
	end

	assign busy       = 1'b0;
	assign done       = done_q;
	assign res_x      = rx_q;
	assign res_y      = ry_q;
	assign res_scalar = rs_q;
	assign div_zero   = dz_q;
	assign overflow   = ovf_q;
endmodule
`default_nettype wire

// ===== rtl/v2alu_checker.sv =====
// port level checks for the 2d vector alu and their binding
`default_nettype none
module v2alu_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        start,
	input wire        busy,
	input wire        done,
	input wire [31:0] res_x,
	input wire [31:0] res_y,
	input wire [31:0] res_scalar,
	input wire        div_zero,
	input wire        overflow
);
	import v2alu_pkg::*;

	// every accepted item gives its result after the fixed latency
	a_lat_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("item without result");

	a_lat_bwd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without item");

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && div_zero) |-> (res_x == '0 && res_y == '0 && res_scalar == '0 && !overflow))
		else $error("zero length result not cleared");

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised");
endmodule

bind vector2d_alu v2alu_checker u_v2alu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.res_x      (res_x),
	.res_y      (res_y),
	.res_scalar (res_scalar),
	.div_zero   (div_zero),
	.overflow   (overflow)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// self-checking testbench for the 2d vector alu with a q16.16 predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import v2alu_pkg::*;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] ax;
		logic [31:0] ay;
		logic [31:0] bx;
		logic [31:0] by;
		logic [31:0] sc;
	} vec_item_t;

	typedef struct packed {
		logic [31:0] rx;
		logic [31:0] ry;
		logic [31:0] rs;
		logic        dz;
		logic        ovf;
	} vec_res_t;

	localparam int WATCHDOG = 20000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  mode;
	logic [31:0] a_x, a_y, b_x, b_y, scalar_in;
	logic        done;
	logic [31:0] res_x, res_y, res_scalar;
	logic        div_zero, overflow;

	vec_item_t pending_items[$];
	vec_res_t  expected_res[$];
	int        errors;
	int        idle_cycles;
	int        gap;
	bit        stim_done;

	vector2d_alu u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y), .scalar_in(scalar_in),
		.done(done), .res_x(res_x), .res_y(res_y), .res_scalar(res_scalar),
		.div_zero(div_zero), .overflow(overflow)
	);

	function automatic logic [63:0] magn(input logic [31:0] x);
		return x[31] ? 64'(-$signed({32'hFFFF_FFFF, x})) : {32'd0, x};
	endfunction

	function automatic logic [31:0] clamp_sm(input logic neg, input logic [64:0] m,
			inout logic ovf);
		if (!neg) begin
			if (m > 65'h7FFF_FFFF) begin
				ovf = 1'b1;
				return 32'h7FFF_FFFF;
			end
			return m[31:0];
		end
		if (m > 65'h8000_0000) begin
			ovf = 1'b1;
			return 32'h8000_0000;
		end
		return -m[31:0];
	endfunction

	function automatic logic [31:0] clamp_s(input logic signed [34:0] x, inout logic ovf);
		logic [64:0] m;
		m = x < 0 ? 65'(-x) : 65'(x);
		return clamp_sm(x < 0, m, ovf);
	endfunction

	function automatic logic [64:0] round_q16(input logic [64:0] m);
		return (m >> 16) + ((m >> 15) & 65'd1);
	endfunction

	function automatic logic [64:0] div_near(input logic [64:0] n, input logic [64:0] d);
		logic [64:0] q, r;
		q = n / d;
		r = n - q * d;
		if (r >= d - r) q++;
		return q;
	endfunction

	function automatic logic [64:0] sqrt_near(input logic [64:0] v);
		logic [64:0] r, b;
		r = 0;
		b = 65'd1 << 64;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		if (v > r) r++;
		return r;
	endfunction

	function automatic vec_res_t vector_result(input vec_item_t it);
		vec_res_t    r;
		logic        o, n1, n2, neg, fneg;
		logic [64:0] m1, m2, m, len, f;
		r = '0;
		o = 1'b0;
		case (it.mode)
			MODE_SUM: begin
				r.rx = clamp_s(35'($signed(it.ax)) + 35'($signed(it.bx)), o);
				r.ry = clamp_s(35'($signed(it.ay)) + 35'($signed(it.by)), o);
			end
			MODE_DIFF: begin
				r.rx = clamp_s(35'($signed(it.ax)) - 35'($signed(it.bx)), o);
				r.ry = clamp_s(35'($signed(it.ay)) - 35'($signed(it.by)), o);
			end
			MODE_DOT: begin
				n1 = it.ax[31] ^ it.bx[31];
				n2 = it.ay[31] ^ it.by[31];
				m1 = magn(it.ax) * magn(it.bx);
				m2 = magn(it.ay) * magn(it.by);
				if (n1 == n2) begin
					neg = n1;
					m = m1 + m2;
				end else if (m1 >= m2) begin
					neg = n1;
					m = m1 - m2;
				end else begin
					neg = n2;
					m = m2 - m1;
				end
				m = round_q16(m);
				r.rs = clamp_sm(neg && m != 0, m, o);
			end
			MODE_PERP: begin
				r.rx = clamp_s(-35'($signed(it.ay)), o);
				r.ry = clamp_s(35'($signed(it.ax)), o);
			end
			MODE_SCALE: begin
				r.rx = clamp_sm(it.ax[31] ^ it.sc[31],
					round_q16(magn(it.ax) * magn(it.sc)), o);
				r.ry = clamp_sm(it.ay[31] ^ it.sc[31],
					round_q16(magn(it.ay) * magn(it.sc)), o);
			end
			default: begin
				len = sqrt_near(magn(it.ax) * magn(it.ax) + magn(it.ay) * magn(it.ay));
				if (it.mode == MODE_LEN) begin
					r.rs = clamp_sm(1'b0, len, o);
				end else if (len == 0) begin
					r.dz = 1'b1;
				end else begin
					f = it.mode == MODE_UNIT ? 65'(ONE_Q) : magn(it.sc);
					fneg = it.mode == MODE_SETL && it.sc[31];
					r.rx = clamp_sm(it.ax[31] ^ fneg, div_near(magn(it.ax) * f, len), o);
					r.ry = clamp_sm(it.ay[31] ^ fneg, div_near(magn(it.ay) * f, len), o);
				end
			end
		endcase
		r.ovf = o;
		return r;
	endfunction

	function automatic logic [31:0] rand_field();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'd0;
			3: return 32'($signed($urandom_range(0, 8)) - 4) <<< 16;
			4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			5: return 32'($signed($urandom_range(0, 200)) - 100) <<< 16;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_item(input logic [2:0] md, input logic [31:0] ax, ay, bx, by, sc);
		vec_item_t it;
		it = '{md, ax, ay, bx, by, sc};
		pending_items.push_back(it);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		logic [2:0] m;
		for (int i = 0; i < 8; i++) begin
			m = 3'(i);
			push_item(m, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
				32'h7FFF_FFFF);
		end
		push_item(MODE_UNIT, 0, 0, 0, 0, 0);
		push_item(MODE_SETL, 0, 0, 0, 0, 32'h0002_0000);
		push_item(MODE_SETL, 32'h0003_0000, 32'h0004_0000, 0, 0, 32'hFFFE_0000);
		push_item(MODE_PERP, 32'h0001_0000, 32'h8000_0000, 0, 0, 0);
		push_item(MODE_LEN, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
		push_item(MODE_UNIT, 32'h0003_0000, 32'hFFFC_0000, 0, 0, 0);
		push_item(MODE_SCALE, 32'h8000_0000, 32'h0000_8000, 0, 0, 32'h8000_0000);
		push_item(MODE_DOT, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_8000, 0);
		push_item(MODE_SUM, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 0);
		push_item(MODE_DIFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 0);
		push_item(MODE_UNIT, 32'h0000_0001, 0, 0, 0, 0);
		for (int i = 0; i < 400; i++) begin
			m = 3'($urandom_range(0, 7));
			push_item(m, rand_field(), rand_field(), rand_field(), rand_field(), rand_field());
		end
		push_item(MODE_DOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		push_item(MODE_SCALE, 32'hFFFF_FFFF, 32'h0, 0, 0, 32'hFFFF_FFFF);
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			mode <= '0;
			a_x <= '0;
			a_y <= '0;
			b_x <= '0;
			b_y <= '0;
			scalar_in <= '0;
			gap <= 0;
			stim_done <= 1'b0;
		end else if (start && busy) begin
			// hold the item until taken
		end else begin
			if (start) expected_res.push_back(vector_result('{mode, a_x, a_y, b_x, b_y,
				scalar_in}));
			if (gap > 0) begin
				gap <= gap - 1;
				start <= 1'b0;
			end else if (pending_items.size() != 0) begin
				vec_item_t it;
				it = pending_items.pop_front();
				start <= 1'b1;
				mode <= it.mode;
				a_x <= it.ax;
				a_y <= it.ay;
				b_x <= it.bx;
				b_y <= it.by;
				scalar_in <= it.sc;
				case ($urandom_range(0, 19))
					0: gap <= $urandom_range(10, 150);
					1, 2, 3, 4: gap <= $urandom_range(1, 3);
					default: gap <= 0;
				endcase
			end else begin
				start <= 1'b0;
				stim_done <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			vec_res_t want;
			if (expected_res.size() == 0) begin
				report("unexpected result", res_x, 0);
			end else begin
				want = expected_res.pop_front();
				if (res_x !== want.rx) report("res_x", res_x, want.rx);
				if (res_y !== want.ry) report("res_y", res_y, want.ry);
				if (res_scalar !== want.rs) report("res_scalar", res_scalar, want.rs);
				if (div_zero !== want.dz) report("div_zero", div_zero, want.dz);
				if (overflow !== want.ovf) report("overflow", overflow, want.ovf);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	initial begin
		errors = 0;
		idle_cycles = 0;
		wait (stim_done && expected_res.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("timeout waiting for results");
		$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/v2alu_pkg.sv
rtl/v2alu_sqrt_cell.sv
rtl/v2alu_div_cell.sv
rtl/vector2d_alu.sv
rtl/v2alu_checker.sv
test/tb_top.sv
